>>> hdl/pmd_pkg.sv
// pmd_pkg: shared types and constants of the paged memory dispatcher
// no dependencies; imported by pmd_ram users and the top level
package pmd_pkg;

  // page register store: 8 halt + 8 user registers in one RAM
  localparam int PAGE_W     = 16;
  localparam int PAGE_DEPTH = 16;
  localparam int PAGE_AW    = $clog2(PAGE_DEPTH);

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 16;
  localparam int OFFSET_W = 22;
  localparam int RAMKB_W  = 13;
  localparam int CAP_W    = 2;

  // operation code bits
  localparam int OP_BYTE_BIT  = 0;
  localparam int OP_WRITE_BIT = 1;

  typedef enum logic [2:0] {
    KIND_RAM  = 3'd0,
    KIND_ROM  = 3'd1,
    KIND_IO   = 3'd2,
    KIND_EMUL = 3'd3,
    KIND_DENY = 3'd4
  } kind_t;

  // ram size limits in kilobytes
  localparam logic [RAMKB_W-1:0] RAMKB_DEFAULT = 13'd512;
  localparam logic [RAMKB_W-1:0] RAMKB_MAX     = 13'd4096;

  // page register bank select in the RAM index
  localparam logic BANK_HALT = 1'b0;
  localparam logic BANK_USER = 1'b1;

  // address map
  localparam logic [3:0]        IO_NIBBLE   = 4'hE;   // 0160000-0167777
  localparam logic [3:0]        EMUL_NIBBLE = 4'hF;   // 0170000 and up
  localparam logic [ADDR_W-1:0] EMUL_MASK   = 16'o007777;
  localparam logic [ADDR_W-1:0] PG_PORT_BASE = 16'o161200;

  // port addresses
  localparam logic [ADDR_W-1:0] PORT_CAPTURE = 16'o161032;
  localparam logic [ADDR_W-1:0] PORT_ZERO    = 16'o161060;
  localparam logic [ADDR_W-1:0] PORT_CONST   = 16'o161062;
  localparam logic [DATA_W-1:0] CONST_VALUE  = 16'h000f;

  // writes accepted and dropped
  localparam logic [ADDR_W-1:0] PORT_W00 = 16'o161000;
  localparam logic [ADDR_W-1:0] PORT_W02 = 16'o161002;
  localparam logic [ADDR_W-1:0] PORT_W12 = 16'o161012;
  localparam logic [ADDR_W-1:0] PORT_W14 = 16'o161014;
  localparam logic [ADDR_W-1:0] PORT_W16 = 16'o161016;
  localparam logic [ADDR_W-1:0] PORT_W26 = 16'o161026;
  localparam logic [ADDR_W-1:0] PORT_W30 = 16'o161030;
  localparam logic [ADDR_W-1:0] PORT_W34 = 16'o161034;
  localparam logic [ADDR_W-1:0] PORT_W36 = 16'o161036;
  localparam logic [ADDR_W-1:0] PORT_W66 = 16'o161066;
  localparam logic [ADDR_W-1:0] PORT_W412 = 16'o161412;

  function automatic logic wr_ignored(input logic [ADDR_W-1:0] a);
    logic hit;
    begin
      hit = (a == PORT_W00) || (a == PORT_W02) || (a == PORT_W12) ||
            (a == PORT_W14) || (a == PORT_W16) || (a == PORT_W26) ||
            (a == PORT_W30) || (a == PORT_CAPTURE) || (a == PORT_W34) ||
            (a == PORT_W36) || (a == PORT_ZERO) || (a == PORT_CONST) ||
            (a == PORT_W66) || (a == PORT_W412);
      return hit;
    end
  endfunction

endpackage

>>> hdl/pmd_ram.sv
// pmd_ram: generic single-write, single-read RAM with registered read data
// no dependencies; read during write to the same entry returns the old word
module pmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/paged_memory_dispatcher.sv
// paged_memory_dispatcher: top level, bus access decode and page translation
// depends on pmd_pkg and pmd_ram (page register store)
//
// usage:
//   in_* channel carries one bus access per beat (operation, address,
//   halt_mode, write_data); out_* channel returns one result beat per access
//   (access_kind, mem_offset, port_read_data, bus_error), in order.
//   cfg_* channel writes the installed ram size in kilobytes; cfg_ready is
//   always high, write it only while no access is in flight.
// timing:
//   one access per cycle sustained while out_ready is high. an accepted beat reads
//   its page register from the page RAM at the accept edge, is resolved in the
//   resolve stage and then lands in the output register that drives out_valid.
//   the rate is set by the page RAM read-modify-write loop: one read and one
//   write per cycle, with the last write forwarded to a read that was issued in
//   the same cycle.
// reset:
//   page registers read as zero (valid bits), capture status cleared, ram
//   size back to 512 KB; no clearing pass, the block is ready at once.
// stall:
//   when out_ready is low the result holds; one more access may wait in the
//   resolve stage, after that in_ready drops.
module paged_memory_dispatcher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_operation,
  input  logic [pmd_pkg::ADDR_W-1:0]    in_address,
  input  logic                          in_halt_mode,
  input  logic [pmd_pkg::DATA_W-1:0]    in_write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_access_kind,
  output logic [pmd_pkg::OFFSET_W-1:0]  out_mem_offset,
  output logic [pmd_pkg::DATA_W-1:0]    out_port_read_data,
  output logic                          out_bus_error,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pmd_pkg::RAMKB_W-1:0]   cfg_ram_size_kbytes
);

  import pmd_pkg::*;

  // configuration
  logic [RAMKB_W-1:0] ram_lim_r;
  logic [RAMKB_W-1:0] ram_lim_nxt;

  // accept side
  logic               in_acc;
  logic               in_io;
  logic [PAGE_AW-1:0] in_idx;

  // resolve stage
  logic               s1_valid_r;
  logic [1:0]         s1_op_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic               s1_halt_r;
  logic [DATA_W-1:0]  s1_wdata_r;
  logic [PAGE_AW-1:0] s1_idx_r;
  logic               s1_adv;

  // page store and forwarding
  logic [PAGE_W-1:0]     ram_q;
  logic                  ram_we;
  logic [PAGE_AW-1:0]    ram_waddr;
  logic [PAGE_W-1:0]     ram_wdata;
  logic [PAGE_DEPTH-1:0] pg_valid_r;
  logic                  fwd_valid_r;
  logic [PAGE_AW-1:0]    fwd_addr_r;
  logic [PAGE_W-1:0]     fwd_data_r;
  logic [PAGE_W-1:0]     pg_word;

  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_nxt;

  // resolve logic
  logic                  is_byte;
  logic                  is_write;
  logic [ADDR_W-1:0]     port_a;
  logic                  pg_port;
  logic                  rd_known;
  logic [DATA_W-1:0]     rd_word;
  logic                  wr_known;
  logic [DATA_W-1:0]     merged;
  logic [OFFSET_W:0]     lin_addr;
  kind_t                 kind_nxt;
  logic [OFFSET_W-1:0]   offset_nxt;
  logic [DATA_W-1:0]     rdata_nxt;
  logic                  err_nxt;

  // output register
  logic                out_valid_r;
  kind_t               out_kind_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [DATA_W-1:0]   out_rdata_r;
  logic                out_err_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (cfg_ram_size_kbytes == '0) begin
      ram_lim_nxt = RAMKB_DEFAULT;
    end else if (cfg_ram_size_kbytes > RAMKB_MAX) begin
      ram_lim_nxt = RAMKB_MAX;
    end else begin
      ram_lim_nxt = cfg_ram_size_kbytes;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_lim_r <= RAMKB_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      ram_lim_r <= ram_lim_nxt;
    end
  end

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // page register index: port number for page ports, page field otherwise
  assign in_io  = (in_address[15:12] == IO_NIBBLE);
  assign in_idx = in_io ? {in_address[4], in_address[3:1]}
                        : {~in_halt_mode, in_address[15:13]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_operation;
      s1_addr_r  <= in_operation[OP_BYTE_BIT] ? in_address
                                              : {in_address[ADDR_W-1:1], 1'b0};
      s1_halt_r  <= in_halt_mode;
      s1_wdata_r <= in_write_data;
      s1_idx_r   <= in_idx;
    end
  end

  pmd_ram #(
    .WIDTH(PAGE_W),
    .DEPTH(PAGE_DEPTH)
  ) u_page_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_acc),
    .raddr(in_idx),
    .rdata(ram_q)
  );

  // a write at the edge that issued our read is not in ram_q yet
  always_comb begin
    priority if (fwd_valid_r && (fwd_addr_r == s1_idx_r)) begin
      pg_word = fwd_data_r;
    end else if (pg_valid_r[s1_idx_r]) begin
      pg_word = ram_q;
    end else begin
      pg_word = '0;
    end
  end

  assign is_byte  = s1_op_r[OP_BYTE_BIT];
  assign is_write = s1_op_r[OP_WRITE_BIT];
  assign port_a   = {s1_addr_r[ADDR_W-1:1], 1'b0};
  assign pg_port  = (port_a[ADDR_W-1:5] == PG_PORT_BASE[ADDR_W-1:5]);
  assign wr_known = pg_port || wr_ignored(port_a);
  assign lin_addr = (OFFSET_W+1)'(s1_addr_r[12:0]) + {1'b0, pg_word[13:4], 12'b0};
  assign merged   = s1_addr_r[0] ? {s1_wdata_r[7:0], rd_word[7:0]}
                                 : {rd_word[15:8], s1_wdata_r[7:0]};

  always_comb begin
    rd_known = 1'b1;
    priority if (port_a == PORT_CAPTURE) begin
      rd_word = {{(DATA_W-CAP_W){1'b0}}, cap_r};
    end else if (port_a == PORT_ZERO) begin
      rd_word = '0;
    end else if (port_a == PORT_CONST) begin
      rd_word = CONST_VALUE;
    end else if (pg_port) begin
      rd_word = pg_word;
    end else begin
      rd_word  = '0;
      rd_known = 1'b0;
    end
  end

  always_comb begin
    kind_nxt   = KIND_RAM;
    offset_nxt = '0;
    rdata_nxt  = '0;
    err_nxt    = 1'b0;
    cap_nxt    = cap_r;
    ram_we     = 1'b0;
    ram_waddr  = s1_idx_r;
    ram_wdata  = s1_wdata_r;
    priority if (s1_halt_r && (s1_addr_r[15:14] == 2'b00)) begin
      kind_nxt   = KIND_ROM;
      offset_nxt = OFFSET_W'(s1_addr_r);
      err_nxt    = is_write;
    end else if (s1_addr_r[15:12] == EMUL_NIBBLE) begin
      kind_nxt   = KIND_EMUL;
      offset_nxt = OFFSET_W'(s1_addr_r & EMUL_MASK);
      ram_wdata  = s1_addr_r;
      // capture into the first free of halt registers 0 and 1
      priority if (!cap_r[0]) begin
        cap_nxt[0] = 1'b1;
        ram_we     = s1_adv;
        ram_waddr  = {BANK_HALT, 3'd0};
      end else if (!cap_r[1]) begin
        cap_nxt[1] = 1'b1;
        ram_we     = s1_adv;
        ram_waddr  = {BANK_HALT, 3'd1};
      end else begin
        cap_nxt = cap_r;
      end
    end else if (s1_addr_r[15:12] == IO_NIBBLE) begin
      kind_nxt = KIND_IO;
      priority if (!is_write) begin
        err_nxt = !rd_known;
        priority if (!is_byte) begin
          rdata_nxt = rd_word;
        end else if (s1_addr_r[0]) begin
          rdata_nxt = {8'b0, rd_word[15:8]};
        end else begin
          rdata_nxt = {8'b0, rd_word[7:0]};
        end
      end else if (!is_byte) begin
        err_nxt   = !wr_known;
        ram_we    = s1_adv && pg_port;
        ram_wdata = s1_wdata_r;
      end else begin
        // byte write: read the word, patch one byte, write it back
        err_nxt   = !rd_known || !wr_known;
        ram_we    = s1_adv && pg_port;
        ram_wdata = merged;
      end
    end else begin
      priority if (pg_word[3]) begin
        kind_nxt = KIND_DENY;
        err_nxt  = 1'b1;
      end else if (lin_addr[OFFSET_W:10] >= ram_lim_r) begin
        kind_nxt = KIND_DENY;
        err_nxt  = 1'b1;
      end else begin
        kind_nxt   = KIND_RAM;
        offset_nxt = lin_addr[OFFSET_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      pg_valid_r  <= '0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        cap_r <= cap_nxt;
      end
      if (ram_we) begin
        pg_valid_r[ram_waddr] <= 1'b1;
        fwd_valid_r           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr_r <= ram_waddr;
      fwd_data_r <= ram_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r   <= kind_nxt;
      out_offset_r <= offset_nxt;
      out_rdata_r  <= rdata_nxt;
      out_err_r    <= err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_access_kind    = out_kind_r;
  assign out_mem_offset     = out_offset_r;
  assign out_port_read_data = out_rdata_r;
  assign out_bus_error      = out_err_r;

`ifndef SYNTHESIS
  a_cap_order: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r[1] |-> cap_r[0])
    else $error("capture bit 1 set without bit 0");

  a_cap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cap_r[0]) |-> cap_r[0])
    else $error("capture bit 0 cleared");

  a_write_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> s1_adv)
    else $error("page write from a stalled beat");

  a_deny_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_DENY)) |-> out_err_r)
    else $error("denied access without bus error");
`endif

endmodule
